// ===== rtl/sha512_sha384_hash_assert.svh =====
// assertion macros for the sha512/sha384 hash block
// included by rtl files that carry concurrent assertions, no other dependencies
`ifndef SHA512_SHA384_HASH_ASSERT_SVH
`define SHA512_SHA384_HASH_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SHA_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sha512 assertion failed");

// next-cycle implication, disabled during reset
`define SHA_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sha512 assertion failed");

`endif

// ===== rtl/sha512_pkg.sv =====
// shared types, constants and round functions of the sha512/sha384 hash block
// no dependencies; used by the schedule, round and top-level files
package sha512_pkg;

  localparam int unsigned Rounds = 80;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [3:0] MaxBytes = 4'd8;
  localparam logic [3:0] LastSlot = 4'd15;
  localparam logic ModeSha512 = 1'b0;
  localparam logic ModeSha384 = 1'b1;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        final_item;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic step;
  } sched_ctrl_t;

  typedef struct packed {
    logic init;
    logic step;
  } round_ctrl_t;

  // index 0 is working variable a / chaining word 0
  typedef logic [7:0][63:0] state_vec_t;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic state_vec_t init_value(input logic mode);
    state_vec_t v;
    if (mode == ModeSha384) begin
      v[0] = 64'hcbbb9d5dc1059ed8; v[1] = 64'h629a292a367cd507;
      v[2] = 64'h9159015a3070dd17; v[3] = 64'h152fecd8f70e5939;
      v[4] = 64'h67332667ffc00b31; v[5] = 64'h8eb44a8768581511;
      v[6] = 64'hdb0c2e0d64f98fa7; v[7] = 64'h47b5481dbefa4fa4;
    end else begin
      v[0] = 64'h6a09e667f3bcc908; v[1] = 64'hbb67ae8584caa73b;
      v[2] = 64'h3c6ef372fe94f82b; v[3] = 64'ha54ff53a5f1d36f1;
      v[4] = 64'h510e527fade682d1; v[5] = 64'h9b05688c2b3e6c1f;
      v[6] = 64'h1f83d9abfb41bd6b; v[7] = 64'h5be0cd19137e2179;
    end
    return v;
  endfunction

  function automatic logic [63:0] round_const(input logic [6:0] idx);
    logic [63:0] k;
    case (idx)
      7'd0:  k = 64'h428a2f98d728ae22;
      7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;
      7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;
      7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;
      7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;
      7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;
      7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;
      7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;
      7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;
      7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;
      7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;
      7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;
      7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;
      7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;
      7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;
      7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;
      7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;
      7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;
      7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;
      7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;
      7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;
      7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;
      7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;
      7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;
      7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;
      7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;
      7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;
      7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;
      7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;
      7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;
      7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;
      7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;
      7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;
      7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;
      7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;
      7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;
      7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;
      7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;
      7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;
      7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/sha512_sha384_hash.sv =====
// Streaming SHA-512 / SHA-384 hash engine, top level with the sequencer.
// Channels: in_* takes 64-bit message words (first byte in bits 63..56),
// out_* returns the digest words, cfg_* writes the one-bit digest mode.
// A transaction moves on a channel when valid is high and stall is low;
// the config write takes place when cfg_valid_i and cfg_ready_o are high,
// and in_stall_o is held high while cfg_valid_i is up so the two never meet.
// The 16th word of a block starts the compression, with in_stall_o high:
// 80 rounds on the one shared round unit, one per cycle, then the chaining
// add. A final word starts padding: pad, zero or length words pushed into
// the schedule window, one or two compressions, then 8 digest words
// (6 in SHA-384 mode) on out_*, one per cycle while out_stall_i is low.
// A stalled output holds its word; input stays stalled until the last digest
// word is taken, then the mode's initial value is reloaded.
// Reset selects SHA-512 and clears the word and bit counters; a mode write,
// taken only while idle, restarts the message in the new mode.
// Depends on sha512_pkg, sha512_sched, sha512_round and the assertion header.
`include "sha512_sha384_hash_assert.svh"

module sha512_sha384_hash (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sha512_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sha512_pkg::out_item_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle,
    StCmp,
    StFin,
    StPad,
    StOut
  } state_e;

  state_e state_q, state_d;
  logic mode_q, mode_d;
  sha512_pkg::state_vec_t chain_q, chain_d;
  logic [3:0] fill_q, fill_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic [6:0] round_q, round_d;
  logic [2:0] idx_q, idx_d;
  logic pad_pend_q, pad_pend_d;
  logic wrap_q, wrap_d;
  logic len_done_q, len_done_d;
  logic final_q, final_d;

  logic push;
  logic [63:0] push_word;
  logic in_acc, cfg_acc, out_acc, block_full;
  logic [3:0] cnt;
  logic [6:0] byte_sh;
  logic [2:0] last_idx;

  sha512_pkg::sched_ctrl_t sched_ctrl;
  sha512_pkg::round_ctrl_t round_ctrl;
  sha512_pkg::state_vec_t v;
  logic [63:0] w_cur;

  // a pending mode write goes first, the message word waits
  assign in_stall_o  = (state_q != StIdle) || cfg_valid_i;
  assign cfg_ready_o = (state_q == StIdle);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign out_acc = out_valid_o && !out_stall_i;
  assign last_idx = (mode_q == sha512_pkg::ModeSha384) ? 3'd5 : 3'd7;

  assign out_data_o.digest_word = chain_q[idx_q];
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = (idx_q == last_idx);

  assign cnt = (in_data_i.byte_count > sha512_pkg::MaxBytes) ? sha512_pkg::MaxBytes
                                                             : in_data_i.byte_count;
  assign byte_sh = {cnt, 3'b000};
  assign block_full = push && (fill_q == sha512_pkg::LastSlot);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    chain_d    = chain_q;
    fill_d     = fill_q;
    bitlen_d   = bitlen_q;
    round_d    = round_q;
    idx_d      = idx_q;
    pad_pend_d = pad_pend_q;
    wrap_d     = wrap_q;
    len_done_d = len_done_q;
    final_d    = final_q;
    push       = 1'b0;
    push_word  = 64'h0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          push = 1'b1;
          if (!in_data_i.final_item) begin
            bitlen_d  = bitlen_q + 64'd64;
            push_word = in_data_i.message_word;
          end else begin
            bitlen_d = bitlen_q + {57'h0, byte_sh};
            final_d  = 1'b1;
            if (cnt == sha512_pkg::MaxBytes) begin
              push_word  = in_data_i.message_word;
              pad_pend_d = 1'b1;
            end else begin
              // keep the valid leading bytes, pad byte right after them
              push_word = (in_data_i.message_word & ~({64{1'b1}} >> byte_sh))
                        | ({sha512_pkg::PadByte, 56'h0} >> byte_sh);
              wrap_d = (fill_q == 4'd14);
            end
          end
        end
      end
      StPad: begin
        push = 1'b1;
        if (pad_pend_q) begin
          push_word  = {sha512_pkg::PadByte, 56'h0};
          pad_pend_d = 1'b0;
          wrap_d     = (fill_q == 4'd14);
        end else if (fill_q == sha512_pkg::LastSlot && !wrap_q) begin
          push_word  = bitlen_q;
          len_done_d = 1'b1;
        end else begin
          // zero-fill up to the length slot, or into a second block when the length has no room
          push_word = 64'h0;
          if (fill_q == sha512_pkg::LastSlot) begin
            wrap_d = 1'b0;
          end
        end
      end
      StCmp: begin
        round_d = round_q + 7'd1;
        if (round_q == 7'(sha512_pkg::Rounds - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + v[i];
        end
        if (len_done_q) begin
          state_d = StOut;
          idx_d   = 3'd0;
        end else if (final_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_acc) begin
          if (idx_q == last_idx) begin
            chain_d    = sha512_pkg::init_value(mode_q);
            fill_d     = 4'd0;
            bitlen_d   = 64'h0;
            final_d    = 1'b0;
            len_done_d = 1'b0;
            pad_pend_d = 1'b0;
            wrap_d     = 1'b0;
            state_d    = StIdle;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (push) begin
      if (block_full) begin
        fill_d  = 4'd0;
        round_d = 7'd0;
        state_d = StCmp;
      end else begin
        fill_d = fill_q + 4'd1;
        if (state_q == StIdle && final_d) begin
          state_d = StPad;
        end
      end
    end

    if (cfg_acc) begin
      mode_d     = cfg_data_i;
      chain_d    = sha512_pkg::init_value(cfg_data_i);
      fill_d     = 4'd0;
      bitlen_d   = 64'h0;
      final_d    = 1'b0;
      len_done_d = 1'b0;
      pad_pend_d = 1'b0;
      wrap_d     = 1'b0;
      state_d    = StIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      mode_q     <= sha512_pkg::ModeSha512;
      chain_q    <= sha512_pkg::init_value(sha512_pkg::ModeSha512);
      fill_q     <= 4'd0;
      bitlen_q   <= 64'h0;
      round_q    <= 7'd0;
      idx_q      <= 3'd0;
      pad_pend_q <= 1'b0;
      wrap_q     <= 1'b0;
      len_done_q <= 1'b0;
      final_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      chain_q    <= chain_d;
      fill_q     <= fill_d;
      bitlen_q   <= bitlen_d;
      round_q    <= round_d;
      idx_q      <= idx_d;
      pad_pend_q <= pad_pend_d;
      wrap_q     <= wrap_d;
      len_done_q <= len_done_d;
      final_q    <= final_d;
    end
  end

  assign sched_ctrl.push = push;
  assign sched_ctrl.step = (state_q == StCmp);
  assign round_ctrl.init = block_full;
  assign round_ctrl.step = (state_q == StCmp);

  sha512_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .word_i (push_word),
    .w_o    (w_cur)
  );

  sha512_round u_round (
    .clk_i   (clk_i),
    .ctrl_i  (round_ctrl),
    .chain_i (chain_q),
    .k_i     (sha512_pkg::round_const(round_q)),
    .w_i     (w_cur),
    .v_o     (v)
  );

  `SHA_ASSERT_IMP(a_no_out_while_ready, clk_i, rst_ni, !in_stall_o, !out_valid_o)
  `SHA_ASSERT_IMP(a_round_in_range, clk_i, rst_ni, state_q == StCmp,
                  round_q < 7'(sha512_pkg::Rounds))
  `SHA_ASSERT_IMP(a_out_index_in_range, clk_i, rst_ni, out_valid_o, idx_q <= last_idx)
  `SHA_ASSERT_NXT(a_ready_after_digest, clk_i, rst_ni,
                  out_acc && out_data_o.last_word, state_q == StIdle && fill_q == 4'd0)

endmodule

// ===== rtl/sha512_sched.sv =====
// message schedule: 16-word sliding window that buffers the block and
// expands it one word per round; depends on sha512_pkg
module sha512_sched (
  input  logic                  clk_i,
  input  sha512_pkg::sched_ctrl_t ctrl_i,
  input  logic [63:0]           word_i,
  output logic [63:0]           w_o
);

  // window slot 0 holds the word for the current round
  logic [15:0][63:0] win_q, win_d;
  logic [63:0] s0, s1, next_w;

  always_comb begin
    s0 = sha512_pkg::rotr(win_q[1], 1) ^ sha512_pkg::rotr(win_q[1], 8) ^ (win_q[1] >> 7);
    s1 = sha512_pkg::rotr(win_q[14], 19) ^ sha512_pkg::rotr(win_q[14], 61)
       ^ (win_q[14] >> 6);
    next_w = s1 + win_q[9] + s0 + win_q[0];
    win_d = win_q;
    if (ctrl_i.push) begin
      win_d = {word_i, win_q[15:1]};
    end else if (ctrl_i.step) begin
      win_d = {next_w, win_q[15:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign w_o = win_q[0];

endmodule

// ===== rtl/sha512_round.sv =====
// compression round unit: working variables a..h and one round per step
// depends on sha512_pkg for the state vector type and rotate function
module sha512_round (
  input  logic                    clk_i,
  input  sha512_pkg::round_ctrl_t ctrl_i,
  input  sha512_pkg::state_vec_t  chain_i,
  input  logic [63:0]             k_i,
  input  logic [63:0]             w_i,
  output sha512_pkg::state_vec_t  v_o
);

  sha512_pkg::state_vec_t v_q, v_d;
  logic [63:0] big_s0, big_s1, ch, maj, t1, t2;

  always_comb begin
    big_s1 = sha512_pkg::rotr(v_q[4], 14) ^ sha512_pkg::rotr(v_q[4], 18)
           ^ sha512_pkg::rotr(v_q[4], 41);
    big_s0 = sha512_pkg::rotr(v_q[0], 28) ^ sha512_pkg::rotr(v_q[0], 34)
           ^ sha512_pkg::rotr(v_q[0], 39);
    ch  = v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]));
    maj = (v_q[0] & v_q[1]) | ((v_q[0] | v_q[1]) & v_q[2]);
    t1  = v_q[7] + big_s1 + ch + k_i + w_i;
    t2  = big_s0 + maj;
    v_d = v_q;
    if (ctrl_i.init) begin
      v_d = chain_i;
    end else if (ctrl_i.step) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign v_o = v_q;

endmodule

// ===== tb/sha512_sha384_hash_tb.sv =====
// self-checking testbench for the streaming sha-512/sha-384 hash block
// needs sha512_pkg for the channel item types and the digest mode codes
module sha512_sha384_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomWords = 330;
  localparam int PhaseWords = 50;
  localparam int SettleCycles = 120;
  localparam int MaxIdle = 11;
  localparam logic [7:0] PadMark = 8'h80;
  localparam int LengthSlot = 15;

  localparam logic [0:79][63:0] RoundK = {
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [0:7][63:0] Iv512 = {
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [0:7][63:0] Iv384 = {
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  class digest_scoreboard;
    logic                  mode;
    logic [63:0]           chain [8];
    logic [63:0]           block_words [16];
    int unsigned           fill;
    logic [63:0]           bit_count;
    sha512_pkg::out_item_t expected_words [$];
    int unsigned           mismatch_count;
    int unsigned           words_checked;
    int unsigned           messages_hashed;

    function new();
      mode = sha512_pkg::ModeSha512;
      mismatch_count = 0;
      words_checked = 0;
      messages_hashed = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++)
        chain[i] = (mode == sha512_pkg::ModeSha384) ? Iv384[i] : Iv512[i];
      fill = 0;
      bit_count = '0;
    endfunction

    function void select_mode(logic m);
      mode = m;
      restart();
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function logic [63:0] ror(logic [63:0] x, int unsigned n);
      logic [127:0] d;
      d = {x, x} >> n;
      return d[63:0];
    endfunction

    function void compress();
      logic [63:0] w [80];
      logic [63:0] v [8];
      logic [63:0] t1, t2, a, e, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = block_words[i];
      for (int i = 16; i < 80; i++) begin
        s0 = ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7);
        s1 = ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6);
        w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 80; i++) begin
        e = v[4];
        a = v[0];
        t1 = v[7] + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41))
           + (v[6] ^ (e & (v[5] ^ v[6]))) + RoundK[i] + w[i];
        t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39)) + ((a & v[1]) | ((a | v[1]) & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    function void push(logic [63:0] w);
      block_words[fill] = w;
      fill++;
      if (fill == 16) begin
        compress();
        fill = 0;
      end
    endfunction

    // one accepted message word; a final word pads and queues the digest
    function void note_message_word(sha512_pkg::in_item_t it);
      int nbytes;
      int nwords;
      logic [63:0] keep;
      sha512_pkg::out_item_t dw;
      if (!it.final_item) begin
        bit_count += 64;
        push(it.message_word);
        return;
      end
      nbytes = (it.byte_count > 8) ? 8 : int'(it.byte_count);
      bit_count += 64'(nbytes * 8);
      if (nbytes == 8) begin
        push(it.message_word);
        push({PadMark, 56'h0});
      end else begin
        keep = ~64'h0 << (64 - 8 * nbytes);
        push((it.message_word & keep) | (64'(PadMark) << (56 - 8 * nbytes)));
      end
      // no room for the length word, close this block with zeros
      if (fill > LengthSlot - 1) begin
        while (fill != 0) push('0);
      end
      while (fill < LengthSlot) push('0);
      push(bit_count);
      nwords = (mode == sha512_pkg::ModeSha384) ? 6 : 8;
      for (int j = 0; j < nwords; j++) begin
        dw.digest_word = chain[j];
        dw.word_index = 3'(j);
        dw.last_word = (j == nwords - 1);
        expected_words.push_back(dw);
      end
      messages_hashed++;
      restart();
    endfunction

    task flag_mismatch(string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_digest_word(sha512_pkg::out_item_t got);
      sha512_pkg::out_item_t want;
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected digest word %h index %0d",
                                got.digest_word, got.word_index));
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (got.digest_word !== want.digest_word)
        flag_mismatch($sformatf("digest word %0d: got %h want %h", want.word_index,
                                got.digest_word, want.digest_word));
      if (got.word_index !== want.word_index)
        flag_mismatch($sformatf("word index: got %0d want %0d", got.word_index,
                                want.word_index));
      if (got.last_word !== want.last_word)
        flag_mismatch($sformatf("last flag on word %0d: got %b want %b", want.word_index,
                                got.last_word, want.last_word));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  sha512_pkg::in_item_t  in_data;
  logic                  out_valid;
  logic                  out_stall;
  sha512_pkg::out_item_t out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_data;

  digest_scoreboard board;
  bit calm_in;
  bit calm_out;
  int items_sent;
  int mode_writes;

  sha512_sha384_hash dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int idle_cycles(bit calm);
    return calm ? 0 : $urandom_range(MaxIdle, 0);
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // called and returns at a falling edge; valid stays up for a back-to-back word
  task automatic send_item(logic [63:0] w, logic [3:0] cnt, logic fin);
    int gap;
    gap = idle_cycles(calm_in);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{message_word: w, byte_count: cnt, final_item: fin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_message_word(in_data);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int body_len, logic [63:0] tail, logic [3:0] tail_count);
    for (int i = 0; i < body_len; i++) send_item(rand_word(), 4'($urandom_range(15, 0)), 1'b0);
    send_item(tail, tail_count, 1'b1);
  endtask

  // idle the input and let every outstanding digest word and compression finish
  task automatic settle();
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_valid = 1'b1;
    cfg_data = m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.select_mode(m);
    mode_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // digest word receiver
  initial begin
    int gap;
    out_stall = 1'b1;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = idle_cycles(calm_out);
      if (gap > 0) begin
        out_stall = 1'b1;
        do @(posedge clk); while (!out_valid);
        @(negedge clk);
        repeat (gap - 1) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_digest_word(out_data);
      @(negedge clk);
    end
  end

  initial begin
    int random_start;
    int phase_start;
    int roll;
    int body_len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    calm_in = 1'b0;
    calm_out = 1'b0;
    items_sent = 0;
    mode_writes = 0;
    board = new();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    write_mode(sha512_pkg::ModeSha512);
    // empty message with junk in the unused bytes
    send_message(0, '1, 4'd0);
    // full final word, pad byte opens the next word
    send_message(0, '1, 4'd8);
    // byte counts above eight saturate
    send_message(0, rand_word(), 4'd15);
    send_message(1, rand_word(), 4'd9);
    // length word does not fit, a second block is needed
    send_message(14, '1, 4'd3);
    settle();
    write_mode(sha512_pkg::ModeSha384);
    send_message(0, '0, 4'd0);
    send_message(0, '1, 4'd8);
    // partial message dropped by a mode write
    for (int i = 0; i < 3; i++) send_item(rand_word(), 4'($urandom_range(15, 0)), 1'b0);
    settle();
    write_mode(sha512_pkg::ModeSha512);

    random_start = items_sent;
    while (items_sent - random_start < RandomWords) begin
      settle();
      write_mode(1'($urandom_range(1, 0)));
      calm_in = ($urandom_range(3, 0) == 0);
      calm_out = ($urandom_range(3, 0) == 0);
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseWords &&
             items_sent - random_start < RandomWords) begin
        roll = $urandom_range(9, 0);
        if (roll < 3) body_len = $urandom_range(3, 0);
        else if (roll < 6) body_len = $urandom_range(17, 13);
        else if (roll < 8) body_len = $urandom_range(12, 4);
        else body_len = $urandom_range(40, 18);
        send_message(body_len, rand_word(), 4'($urandom_range(15, 0)));
      end
      if ($urandom_range(2, 0) == 0) begin
        body_len = $urandom_range(20, 1);
        for (int i = 0; i < body_len; i++)
          send_item(rand_word(), 4'($urandom_range(15, 0)), 1'b0);
      end
    end
    settle();

    $display("run covered %0d message words in %0d complete messages over %0d mode writes",
             items_sent, board.messages_hashed, mode_writes);
    $display("%0d digest words compared, %0d mismatches", board.words_checked,
             board.mismatch_count);
    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout waiting on the hash block");
    $display("FAILURE");
    $finish;
  end

endmodule
